### rtl/rtcsi_pkg.sv
// Package with the types, constants and helper functions of the three-wire RTC serial interface.
package rtcsi_pkg;

   localparam int BUFFER_BYTES = 7;

   localparam logic [3:0] CMD_NIBBLE = 4'b0110;

   typedef enum logic {
      PORT_WRITE = 1'b0,
      PORT_READ  = 1'b1
   } port_op_type;

   typedef enum logic [1:0] {
      PH_COMMAND = 2'd0,
      PH_RECEIVE = 2'd1,
      PH_SEND    = 2'd2
   } phase_type;

   typedef enum logic [2:0] {
      REG_STATUS_ONE = 3'd0,
      REG_STATUS_TWO = 3'd1,
      REG_DATE_TIME  = 3'd2,
      REG_TIME       = 3'd3,
      REG_INT_ONE    = 3'd4,
      REG_INT_TWO    = 3'd5,
      REG_CLOCK_ADJ  = 3'd6,
      REG_FREE       = 3'd7
   } rtc_reg_type;

   typedef struct packed {
      logic       command;
      logic [7:0] write_value;
      logic [6:0] year_in_century;
      logic [3:0] month_number;
      logic [4:0] day_of_month;
      logic [2:0] day_of_week;
      logic [4:0] hour_now;
      logic [5:0] minute_now;
      logic [5:0] second_now;
   } req_item_type;

   typedef struct packed {
      logic [6:0] port_value;
      logic       bad_command;
   } rsp_item_type;

   // Number of data bytes that follow the command byte for each register.
   function automatic logic [2:0] reg_bytes(input logic [2:0] sel);
      logic [2:0] n;
      case (sel)
         REG_DATE_TIME: n = 3'd7;
         REG_TIME:      n = 3'd3;
         REG_INT_ONE:   n = 3'd3;
         REG_INT_TWO:   n = 3'd3;
         default:       n = 3'd1;
      endcase
      return n;
   endfunction

   // Binary to BCD, exact for values below 100; tens come from a reciprocal multiply.
   function automatic logic [7:0] to_bcd(input logic [6:0] v);
      logic [14:0] prod;
      logic [3:0]  tens;
      logic [6:0]  ones;
      prod = 15'(v) * 15'd205;
      tens = prod[14:11];
      ones = v - (7'(tens) * 7'd10);
      return {tens, ones[3:0]};
   endfunction

   // Full bit reversal of a byte.
   function automatic logic [7:0] reverse_byte(input logic [7:0] d);
      logic [7:0] r;
      for (int i = 0; i < 8; i++) begin
         r[i] = d[7 - i];
      end
      return r;
   endfunction

endpackage

### rtl/rtcsi_ifs.sv
// Valid/ready channel interfaces for the request and response transactions.
interface rtcsi_req_if import rtcsi_pkg::*; ();
   logic       valid;
   logic       ready;
   logic       command;
   logic [7:0] write_value;
   logic [6:0] year_in_century;
   logic [3:0] month_number;
   logic [4:0] day_of_month;
   logic [2:0] day_of_week;
   logic [4:0] hour_now;
   logic [5:0] minute_now;
   logic [5:0] second_now;

   modport source (output valid, command, write_value, year_in_century, month_number,
                   day_of_month, day_of_week, hour_now, minute_now, second_now,
                   input ready);
   modport sink (input valid, command, write_value, year_in_century, month_number,
                 day_of_month, day_of_week, hour_now, minute_now, second_now,
                 output ready);
endinterface

interface rtcsi_rsp_if import rtcsi_pkg::*; ();
   logic       valid;
   logic       ready;
   logic [6:0] port_value;
   logic       bad_command;

   modport source (output valid, port_value, bad_command, input ready);
   modport sink (input valid, port_value, bad_command, output ready);
endinterface

### rtl/three_wire_rtc_serial_interface.sv
// Top level of the three-wire RTC serial interface behind a GPIO port byte.
//
// Each request transaction is one CPU access to the GPIO port byte. A port write
// sets the SIO/SCK/CS enables from bits 4-6 and updates each enabled level from
// bits 0-2; a rising CS restarts the protocol, and a rising SCK while CS is high
// moves one serial bit, LSB first. The first byte is the command (accepted in
// either bit order), followed by the data bytes of the selected register. Reads
// return the status bytes or the supplied time and date converted to BCD. A port
// read changes nothing. Every request produces exactly one response transaction
// carrying the port byte after the access and a flag for a malformed command.
// Pipeline: a request is captured in an input register, from which the protocol
// state and the response register are updated by one pass of logic; one request
// is accepted every cycle unless the response register stalls the pipeline, which
// happens only while a response waits and the sink is not ready.
module three_wire_rtc_serial_interface import rtcsi_pkg::*; (
   input logic         clock,
   input logic         reset,
   rtcsi_req_if.sink   req_bus,
   rtcsi_rsp_if.source rsp_bus
);

   // Input stage.
   logic         s1_valid_ff, s1_valid_in;
   req_item_type s1_item_ff;
   logic         s1_go;

   // Response stage.
   logic         rsp_valid_ff, rsp_valid_in;
   rsp_item_type rsp_item_ff, rsp_item_in;

   // Protocol state.
   logic       sio_ff, sio_in;
   logic       sck_ff, sck_in;
   logic       cs_ff, cs_in;
   logic [2:0] en_ff, en_in;
   logic [2:0] bit_count_ff, bit_count_in;
   logic [2:0] byte_count_ff, byte_count_in;
   logic [7:0] shift_ff, shift_in;
   logic [7:0] buf_ff [BUFFER_BYTES];
   logic [7:0] buf_in [BUFFER_BYTES];
   phase_type  phase_ff, phase_in;
   logic [2:0] sel_ff, sel_in;
   logic [7:0] status_one_ff, status_one_in;
   logic [7:0] status_two_ff, status_two_in;

   logic       bad;
   logic [2:0] n_bytes;
   logic [7:0] cmd_byte;
   logic [7:0] wv;

   // The input stage moves on when the response register is empty or being drained.
   assign s1_go         = s1_valid_ff && (!rsp_valid_ff || rsp_bus.ready);
   assign req_bus.ready = !s1_valid_ff || s1_go;
   assign s1_valid_in   = req_bus.valid ? 1'b1 : (s1_go ? 1'b0 : s1_valid_ff);
   assign rsp_valid_in  = s1_go ? 1'b1 : (rsp_bus.ready ? 1'b0 : rsp_valid_ff);

   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.port_value  = rsp_item_ff.port_value;
   assign rsp_bus.bad_command = rsp_item_ff.bad_command;

   // Next protocol state for the transaction held in the input stage.
   always_comb begin
      sio_in        = sio_ff;
      sck_in        = sck_ff;
      cs_in         = cs_ff;
      en_in         = en_ff;
      bit_count_in  = bit_count_ff;
      byte_count_in = byte_count_ff;
      shift_in      = shift_ff;
      buf_in        = buf_ff;
      phase_in      = phase_ff;
      sel_in        = sel_ff;
      status_one_in = status_one_ff;
      status_two_in = status_two_ff;
      bad           = 1'b0;
      n_bytes       = reg_bytes(sel_ff);
      cmd_byte      = 8'd0;
      wv            = s1_item_ff.write_value;

      if (s1_item_ff.command == PORT_WRITE) begin
         en_in = wv[6:4];
         if (en_in[0]) begin
            sio_in = wv[0];
         end
         if (en_in[1]) begin
            sck_in = wv[1];
         end
         if (en_in[2]) begin
            cs_in = wv[2];
         end
         // A rising chip select restarts the protocol with a fresh command byte.
         if (!cs_ff && cs_in) begin
            phase_in      = PH_COMMAND;
            bit_count_in  = 3'd0;
            byte_count_in = 3'd0;
         end
         if (cs_in && !sck_ff && sck_in) begin
            case (phase_in)
               PH_RECEIVE: begin
                  if (byte_count_in < n_bytes) begin
                     shift_in[bit_count_in] = sio_in;
                     bit_count_in = bit_count_in + 3'd1;
                     if (bit_count_in == 3'd0) begin
                        if (32'(byte_count_in) < BUFFER_BYTES) begin
                           buf_in[byte_count_in] = shift_in;
                        end
                        byte_count_in = byte_count_in + 3'd1;
                        if (byte_count_in == n_bytes) begin
                           // Only the status registers keep written data.
                           if (sel_ff == REG_STATUS_ONE) begin
                              status_one_in = (status_one_ff & ~8'h0E) | (buf_in[0] & 8'h0E);
                           end else if (sel_ff == REG_STATUS_TWO) begin
                              status_two_in = buf_in[0];
                           end
                           phase_in = PH_COMMAND;
                        end
                     end
                  end
               end
               PH_SEND: begin
                  // The outgoing bit is driven onto SIO whatever its enable.
                  if (32'(byte_count_in) < BUFFER_BYTES) begin
                     sio_in = buf_in[byte_count_in][0];
                     buf_in[byte_count_in] = {1'b0, buf_in[byte_count_in][7:1]};
                  end
                  bit_count_in = bit_count_in + 3'd1;
                  if (bit_count_in == 3'd0) begin
                     byte_count_in = byte_count_in + 3'd1;
                     if (byte_count_in >= n_bytes) begin
                        phase_in = PH_COMMAND;
                     end
                  end
               end
               default: begin
                  shift_in[bit_count_in] = sio_in;
                  bit_count_in = bit_count_in + 3'd1;
                  if (bit_count_in == 3'd0) begin
                     cmd_byte = shift_in;
                     if (cmd_byte[7:4] == CMD_NIBBLE) begin
                        cmd_byte = reverse_byte(cmd_byte);
                        shift_in = cmd_byte;
                     end
                     if (cmd_byte[3:0] != CMD_NIBBLE) begin
                        // Unknown format: drop the byte and wait for another one.
                        bad = 1'b1;
                     end else begin
                        sel_in        = cmd_byte[6:4];
                        byte_count_in = 3'd0;
                        if (cmd_byte[7]) begin
                           phase_in = PH_SEND;
                           case (sel_in)
                              REG_STATUS_ONE: buf_in[0] = status_one_ff;
                              REG_STATUS_TWO: buf_in[0] = status_two_ff;
                              REG_DATE_TIME: begin
                                 buf_in[0] = to_bcd(s1_item_ff.year_in_century);
                                 buf_in[1] = to_bcd(7'(s1_item_ff.month_number));
                                 buf_in[2] = to_bcd(7'(s1_item_ff.day_of_month));
                                 buf_in[3] = to_bcd(7'(s1_item_ff.day_of_week));
                                 buf_in[4] = to_bcd(7'(s1_item_ff.hour_now));
                                 buf_in[5] = to_bcd(7'(s1_item_ff.minute_now));
                                 buf_in[6] = to_bcd(7'(s1_item_ff.second_now));
                              end
                              REG_TIME: begin
                                 buf_in[0] = to_bcd(7'(s1_item_ff.hour_now));
                                 buf_in[1] = to_bcd(7'(s1_item_ff.minute_now));
                                 buf_in[2] = to_bcd(7'(s1_item_ff.second_now));
                              end
                              REG_INT_ONE, REG_INT_TWO: begin
                                 buf_in[0] = 8'd0;
                                 buf_in[1] = 8'd0;
                                 buf_in[2] = 8'd0;
                              end
                              default: buf_in[0] = 8'd0;
                           endcase
                        end else begin
                           phase_in = PH_RECEIVE;
                        end
                     end
                  end
               end
            endcase
         end
      end

      rsp_item_in.port_value  = {en_in, 1'b0, cs_in, sck_in, sio_in};
      rsp_item_in.bad_command = bad;
   end

   // Pipeline registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (req_bus.valid && req_bus.ready) begin
         s1_item_ff.command         <= req_bus.command;
         s1_item_ff.write_value     <= req_bus.write_value;
         s1_item_ff.year_in_century <= req_bus.year_in_century;
         s1_item_ff.month_number    <= req_bus.month_number;
         s1_item_ff.day_of_month    <= req_bus.day_of_month;
         s1_item_ff.day_of_week     <= req_bus.day_of_week;
         s1_item_ff.hour_now        <= req_bus.hour_now;
         s1_item_ff.minute_now      <= req_bus.minute_now;
         s1_item_ff.second_now      <= req_bus.second_now;
      end
      if (s1_go) begin
         rsp_item_ff <= rsp_item_in;
      end
   end

   // Protocol state register.
   always_ff @(posedge clock) begin
      if (reset) begin
         sio_ff        <= 1'b0;
         sck_ff        <= 1'b0;
         cs_ff         <= 1'b0;
         en_ff         <= 3'd0;
         bit_count_ff  <= 3'd0;
         byte_count_ff <= 3'd0;
         shift_ff      <= 8'd0;
         for (int i = 0; i < BUFFER_BYTES; i++) begin
            buf_ff[i] <= 8'd0;
         end
         phase_ff      <= PH_COMMAND;
         sel_ff        <= 3'd0;
         status_one_ff <= 8'd0;
         status_two_ff <= 8'd0;
      end else if (s1_go) begin
         sio_ff        <= sio_in;
         sck_ff        <= sck_in;
         cs_ff         <= cs_in;
         en_ff         <= en_in;
         bit_count_ff  <= bit_count_in;
         byte_count_ff <= byte_count_in;
         shift_ff      <= shift_in;
         buf_ff        <= buf_in;
         phase_ff      <= phase_in;
         sel_ff        <= sel_in;
         status_one_ff <= status_one_in;
         status_two_ff <= status_two_in;
      end
   end

   // A malformed command can only be flagged on a rising SCK with CS high.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_item_ff.bad_command |->
         rsp_item_ff.port_value[2] && rsp_item_ff.port_value[1])
      else $error("bad_command flagged without an SCK edge under CS");

   // The protocol phase only moves when a transaction is processed.
   assert property (@(posedge clock) disable iff (reset)
      !$stable(phase_ff) |-> $past(s1_go || reset))
      else $error("phase changed without a processed transaction");

   // Back-pressure on the request side only comes from a full pipeline.
   assert property (@(posedge clock) disable iff (reset)
      !req_bus.ready |-> s1_valid_ff && rsp_valid_ff && !rsp_bus.ready)
      else $error("request stalled while the pipeline had room");

   // A processed transaction always leaves a response waiting.
   assert property (@(posedge clock) disable iff (reset)
      s1_go |=> rsp_valid_ff)
      else $error("processed transaction produced no response");

endmodule

### tb/rtc_port_check_pkg.sv
// Scoreboard for the three-wire RTC port: a cycle-free predictor of the port byte and its checks.
`timescale 1ns / 1ps
package rtc_port_check_pkg;
   import rtcsi_pkg::*;

   localparam logic [7:0] STATUS_ONE_WRITABLE = 8'h0E;
   localparam int REPORTED_MISMATCHES = 10;

   // Data bytes that follow the command byte, indexed by register select.
   localparam logic [2:0] DATA_BYTES [8] = '{3'd1, 3'd1, 3'd7, 3'd3, 3'd3, 3'd3, 3'd1, 3'd1};

   // Bit reversal done as three swap stages: nibbles, pairs, single bits.
   function automatic logic [7:0] reverse_bits(input logic [7:0] d);
      logic [7:0] r;
      r = {d[3:0], d[7:4]};
      r = ((r & 8'h33) << 2) | ((r & 8'hCC) >> 2);
      r = ((r & 8'h55) << 1) | ((r & 8'hAA) >> 1);
      return r;
   endfunction

   function automatic logic [7:0] bcd_of(input logic [6:0] v);
      int unsigned u;
      u = v;
      return 8'(((u / 10) << 4) | (u % 10));
   endfunction

   class rtc_port_check;
      logic                sio_level, sck_level, cs_level;
      logic [2:0]          pin_enables, bit_count, byte_count, selected_reg;
      logic [7:0]          shift_byte, status_one, status_two;
      logic [7:0]          byte_buffer [BUFFER_BYTES];
      phase_type           phase;
      rsp_item_type        expected_port_bytes [$];
      int                  mismatches, replies_checked, rtc_reads, rtc_writes, bad_commands;

      function new();
         sio_level = 1'b0;
         sck_level = 1'b0;
         cs_level = 1'b0;
         pin_enables = '0;
         bit_count = '0;
         byte_count = '0;
         selected_reg = '0;
         shift_byte = '0;
         status_one = '0;
         status_two = '0;
         foreach (byte_buffer[i]) byte_buffer[i] = '0;
         phase = PH_COMMAND;
         mismatches = 0;
         replies_checked = 0;
         rtc_reads = 0;
         rtc_writes = 0;
         bad_commands = 0;
      endfunction

      function void buf_put(input int unsigned i, input logic [7:0] v);
         if (i < BUFFER_BYTES) begin
            byte_buffer[i] = v;
         end
      endfunction

      // Shifts the SIO level into the next bit position; true once a byte is complete.
      function bit shift_in_sio();
         shift_byte[bit_count] = sio_level;
         bit_count++;
         return bit_count == 3'd0;
      endfunction

      // A read command fills the buffer with the selected register's bytes.
      function void load_register(input req_item_type item);
         case (selected_reg)
            REG_STATUS_ONE: buf_put(0, status_one);
            REG_STATUS_TWO: buf_put(0, status_two);
            REG_DATE_TIME: begin
               buf_put(0, bcd_of(item.year_in_century));
               buf_put(1, bcd_of(7'(item.month_number)));
               buf_put(2, bcd_of(7'(item.day_of_month)));
               buf_put(3, bcd_of(7'(item.day_of_week)));
               buf_put(4, bcd_of(7'(item.hour_now)));
               buf_put(5, bcd_of(7'(item.minute_now)));
               buf_put(6, bcd_of(7'(item.second_now)));
            end
            REG_TIME: begin
               buf_put(0, bcd_of(7'(item.hour_now)));
               buf_put(1, bcd_of(7'(item.minute_now)));
               buf_put(2, bcd_of(7'(item.second_now)));
            end
            REG_INT_ONE, REG_INT_TWO: begin
               buf_put(0, 8'd0);
               buf_put(1, 8'd0);
               buf_put(2, 8'd0);
            end
            default: buf_put(0, 8'd0);
         endcase
      endfunction

      function void store_register();
         if (selected_reg == REG_STATUS_ONE) begin
            status_one = (status_one & ~STATUS_ONE_WRITABLE) |
                         (byte_buffer[0] & STATUS_ONE_WRITABLE);
         end else if (selected_reg == REG_STATUS_TWO) begin
            status_two = byte_buffer[0];
         end
      endfunction

      // Returns true when a completed command byte has an unknown format.
      function bit command_bit(input req_item_type item);
         logic [7:0] d;
         if (!shift_in_sio()) begin
            return 1'b0;
         end
         d = shift_byte;
         if (d[7:4] == CMD_NIBBLE) begin
            d = reverse_bits(d);
            shift_byte = d;
         end else if (d[3:0] != CMD_NIBBLE) begin
            bad_commands++;
            return 1'b1;
         end
         selected_reg = d[6:4];
         bit_count = '0;
         byte_count = '0;
         if (d[7]) begin
            load_register(item);
            phase = PH_SEND;
            rtc_reads++;
         end else begin
            phase = PH_RECEIVE;
            rtc_writes++;
         end
         return 1'b0;
      endfunction

      function void receive_bit();
         logic [2:0] n;
         n = DATA_BYTES[selected_reg];
         if (byte_count < n) begin
            if (shift_in_sio()) begin
               buf_put(byte_count, shift_byte);
               byte_count++;
               if (byte_count == n) begin
                  store_register();
                  phase = PH_COMMAND;
               end
            end
         end
      endfunction

      function void send_bit();
         logic [2:0] n;
         n = DATA_BYTES[selected_reg];
         if (byte_count < BUFFER_BYTES) begin
            sio_level = byte_buffer[byte_count][0];
            byte_buffer[byte_count] = byte_buffer[byte_count] >> 1;
         end
         bit_count++;
         if (bit_count == 3'd0) begin
            byte_count++;
            if (byte_count >= n) begin
               phase = PH_COMMAND;
            end
         end
      endfunction

      // Advances the port and protocol state by one accepted access and queues its reply.
      function void note_access(input req_item_type item);
         logic [7:0]   v;
         logic         old_sck, old_cs, bad;
         rsp_item_type expected;
         bad = 1'b0;
         if (item.command == PORT_WRITE) begin
            v = item.write_value;
            old_sck = sck_level;
            old_cs = cs_level;
            pin_enables = v[6:4];
            if (pin_enables[0]) sio_level = v[0];
            if (pin_enables[1]) sck_level = v[1];
            if (pin_enables[2]) cs_level = v[2];
            if (!old_cs && cs_level) begin
               phase = PH_COMMAND;
               bit_count = '0;
               byte_count = '0;
            end
            if (cs_level && !old_sck && sck_level) begin
               if (phase == PH_RECEIVE) begin
                  receive_bit();
               end else if (phase == PH_SEND) begin
                  send_bit();
               end else begin
                  bad = command_bit(item);
               end
            end
         end
         expected.port_value = {pin_enables, 1'b0, cs_level, sck_level, sio_level};
         expected.bad_command = bad;
         expected_port_bytes.push_back(expected);
      endfunction

      // Compares one reply against the oldest predicted port byte.
      function void check_reply(input rsp_item_type got);
         rsp_item_type expected;
         if (expected_port_bytes.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORTED_MISMATCHES) begin
               $display("unexpected reply: port_value=%02h bad_command=%0b",
                        got.port_value, got.bad_command);
            end
            return;
         end
         expected = expected_port_bytes.pop_front();
         replies_checked++;
         if (got !== expected) begin
            mismatches++;
            if (mismatches <= REPORTED_MISMATCHES) begin
               $display("reply %0d: expected port_value=%02h bad_command=%0b, got %02h %0b",
                        replies_checked, expected.port_value, expected.bad_command,
                        got.port_value, got.bad_command);
            end
         end
      endfunction
   endclass
endpackage

### tb/testbench.sv
// Top-level testbench: drives port accesses into the RTC serial interface and checks every reply.
`timescale 1ns / 1ps
module testbench;
   import rtcsi_pkg::*;
   import rtc_port_check_pkg::*;

   localparam int HALF_PERIOD     = 6;
   localparam int RESET_CYCLES    = 8;
   localparam int ITEMS_PER_PHASE = 365;
   localparam int HOLD_OFF_CYCLES = 200;
   localparam int STALL_LIMIT     = 3000;
   localparam int DRAIN_CYCLES    = 8;

   logic clock = 1'b0;
   logic reset = 1'b1;

   rtcsi_req_if req_bus();
   rtcsi_rsp_if rsp_bus();

   three_wire_rtc_serial_interface u_top (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   rtc_port_check board = new();

   int source_idle_pct = 12;
   int sink_idle_pct   = 82;
   int accesses_sent   = 0;
   int hold_left       = 0;
   int hold_offs       = 0;
   int quiet_cycles    = 0;
   bit hold_off_request = 1'b0;

   // Port accesses waiting to be offered, built a few transfers at a time.
   req_item_type script [$];

   always begin
      #HALF_PERIOD clock = 1'b1;
      #HALF_PERIOD clock = 1'b0;
   end

   // Port byte with SCK and CS enabled; the SIO enable is chosen by the caller.
   function automatic logic [7:0] port_byte(input logic sio, input logic sck,
                                            input logic cs, input logic sio_en);
      return {1'b0, 1'b1, 1'b1, sio_en, 1'b0, cs, sck, sio};
   endfunction

   // Mostly in-range time fields, now and then arbitrary values of full width.
   function automatic req_item_type make_item(input port_op_type op, input logic [7:0] value);
      req_item_type item;
      item.command     = op;
      item.write_value = value;
      if ($urandom_range(9) == 0) begin
         item.year_in_century = 7'($urandom);
         item.month_number    = 4'($urandom);
         item.day_of_month    = 5'($urandom);
         item.day_of_week     = 3'($urandom);
         item.hour_now        = 5'($urandom);
         item.minute_now      = 6'($urandom);
         item.second_now      = 6'($urandom);
      end else begin
         item.year_in_century = 7'($urandom_range(99));
         item.month_number    = 4'($urandom_range(12, 1));
         item.day_of_month    = 5'($urandom_range(31, 1));
         item.day_of_week     = 3'($urandom_range(6));
         item.hour_now        = 5'($urandom_range(23));
         item.minute_now      = 6'($urandom_range(59));
         item.second_now      = 6'($urandom_range(59));
      end
      return item;
   endfunction

   // One serial bit: SIO set with SCK low, then SCK raised; sometimes followed by a port read.
   function automatic void push_bit(input logic b, input logic sio_en);
      script.push_back(make_item(PORT_WRITE, port_byte(b, 1'b0, 1'b1, sio_en)));
      script.push_back(make_item(PORT_WRITE, port_byte(b, 1'b1, 1'b1, sio_en)));
      if ($urandom_range(15) == 0) begin
         script.push_back(make_item(PORT_READ, 8'($urandom)));
      end
   endfunction

   function automatic void refill();
      int         kind;
      int         n_bits;
      logic [2:0] sel;
      logic       sio_en;
      logic [7:0] cmd;
      kind = $urandom_range(9);
      if (kind < 2) begin
         // Loose port traffic with arbitrary enables and levels.
         repeat ($urandom_range(6, 1)) begin
            script.push_back(make_item(port_op_type'($urandom_range(1)), 8'($urandom)));
         end
      end else begin
         sel = 3'($urandom_range(7));
         cmd = {1'($urandom_range(1)), sel, CMD_NIBBLE};
         if (kind == 2) begin
            cmd[3:0] = 4'($urandom);
         end
         sio_en = !cmd[7] || ($urandom_range(1) == 1);
         if ($urandom_range(1) == 1) begin
            cmd = reverse_byte(cmd);
         end
         script.push_back(make_item(PORT_WRITE, port_byte(1'b0, 1'b0, 1'b0, 1'b1)));
         script.push_back(make_item(PORT_WRITE, port_byte(1'b0, 1'b0, 1'b1, 1'b1)));
         for (int i = 0; i < 8; i++) begin
            push_bit(cmd[i], 1'b1);
         end
         n_bits = 8 * int'(DATA_BYTES[sel]);
         if ($urandom_range(3) == 0) begin
            n_bits = $urandom_range(n_bits + 4);
         end
         for (int i = 0; i < n_bits; i++) begin
            push_bit(1'($urandom_range(1)), sio_en);
         end
      end
   endfunction

   function automatic req_item_type next_item();
      if (script.size() == 0) begin
         refill();
      end
      return script.pop_front();
   endfunction

   // Offers count accesses, idling the sender at the current rate.
   task automatic drive_items(input int count);
      req_item_type item;
      int           sent;
      sent = 0;
      while (sent < count) begin
         if ($urandom_range(99) < source_idle_pct) begin
            req_bus.valid <= 1'b0;
            @(posedge clock);
         end else begin
            item = next_item();
            req_bus.valid           <= 1'b1;
            req_bus.command         <= item.command;
            req_bus.write_value     <= item.write_value;
            req_bus.year_in_century <= item.year_in_century;
            req_bus.month_number    <= item.month_number;
            req_bus.day_of_month    <= item.day_of_month;
            req_bus.day_of_week     <= item.day_of_week;
            req_bus.hour_now        <= item.hour_now;
            req_bus.minute_now      <= item.minute_now;
            req_bus.second_now      <= item.second_now;
            @(posedge clock);
            while (!req_bus.ready) begin
               @(posedge clock);
            end
            sent++;
            accesses_sent++;
         end
      end
   endtask

   // Receiver: random idling, plus one long hold-off when requested.
   initial begin
      rsp_bus.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_off_request && hold_offs == 0 && hold_left == 0) begin
            hold_left = HOLD_OFF_CYCLES;
         end
         if (hold_left > 0) begin
            rsp_bus.ready <= 1'b0;
            hold_left--;
            if (hold_left == 0) begin
               hold_offs++;
            end
         end else begin
            rsp_bus.ready <= ($urandom_range(99) >= sink_idle_pct);
         end
      end
   end

   // Monitor and watchdog.
   always @(posedge clock) begin : monitor
      req_item_type seen_req;
      rsp_item_type seen_rsp;
      if (!reset) begin
         quiet_cycles++;
         if (req_bus.valid && req_bus.ready) begin
            seen_req.command         = req_bus.command;
            seen_req.write_value     = req_bus.write_value;
            seen_req.year_in_century = req_bus.year_in_century;
            seen_req.month_number    = req_bus.month_number;
            seen_req.day_of_month    = req_bus.day_of_month;
            seen_req.day_of_week     = req_bus.day_of_week;
            seen_req.hour_now        = req_bus.hour_now;
            seen_req.minute_now      = req_bus.minute_now;
            seen_req.second_now      = req_bus.second_now;
            board.note_access(seen_req);
            quiet_cycles = 0;
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            seen_rsp.port_value  = rsp_bus.port_value;
            seen_rsp.bad_command = rsp_bus.bad_command;
            board.check_reply(seen_rsp);
            quiet_cycles = 0;
         end
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("Watchdog: no transaction for %0d cycles.", STALL_LIMIT);
            $display("FAILED: results differ");
            $finish;
         end
      end
   end

   initial begin
      req_bus.valid           = 1'b0;
      req_bus.command         = PORT_READ;
      req_bus.write_value     = '0;
      req_bus.year_in_century = '0;
      req_bus.month_number    = '0;
      req_bus.day_of_month    = '0;
      req_bus.day_of_week     = '0;
      req_bus.hour_now        = '0;
      req_bus.minute_now      = '0;
      req_bus.second_now      = '0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      drive_items(ITEMS_PER_PHASE);
      source_idle_pct = 82;
      sink_idle_pct   = 12;
      drive_items(ITEMS_PER_PHASE);
      source_idle_pct  = 0;
      sink_idle_pct    = 0;
      hold_off_request = 1'b1;
      drive_items(ITEMS_PER_PHASE);
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (board.expected_port_bytes.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("Sent %0d port accesses: %0d serial reads, %0d serial writes, %0d bad commands.",
               accesses_sent, board.rtc_reads, board.rtc_writes, board.bad_commands);
      $display("Traffic ran with an idle sender, an idle receiver, back to back and %0d stall(s).",
               hold_offs);
      if (board.mismatches == 0 && board.replies_checked == accesses_sent &&
          board.expected_port_bytes.size() == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end
endmodule
